FILE: hw/rtl/fixed_point_alu_q24_8_macros.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FPA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FPA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/fpa_pkg.sv
// shared types and codes of the fixed-point alu
`default_nettype none
package fpa_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_EQ = 4'd4, OP_NE = 4'd5, OP_GT = 4'd6, OP_LT = 4'd7,
        OP_GE = 4'd8, OP_LE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
    } t_op;
    localparam int OP_BITS = 4;
endpackage
`default_nettype wire

FILE: hw/rtl/fpa_if.sv
// valid/ready channel interface
`default_nettype none
interface fpa_if #(parameter int W = 32) (input wire logic i_clk);
    logic         valid;
    logic         ready;
    logic [3:0]   operation;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    logic [W-1:0] result_value;
    logic         compare_true;
    logic         overflow;
    logic         divide_by_zero;
    modport source (output valid, operation, operand_a, operand_b, result_value,
                    compare_true, overflow, divide_by_zero, input ready);
    modport sink (input valid, operation, operand_a, operand_b, result_value,
                  compare_true, overflow, divide_by_zero, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fpa_cell.sv
// one stage of the alu pipeline: a restoring divide step plus carried payload
`default_nettype none
module fpa_cell
    import fpa_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 32,
    parameter int QB = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_rem,
    input  wire logic [NW-1:0] i_quo,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_res,
    input  wire logic [3:0]    i_flg,
    input  wire logic          i_neg,
    input  wire logic [3:0]    i_op,
    output logic               o_vld,
    output logic      [NW-1:0] o_rem,
    output logic      [NW-1:0] o_quo,
    output logic      [DW-1:0] o_den,
    output logic      [DW-1:0] o_res,
    output logic      [3:0]    o_flg,
    output logic               o_neg,
    output logic      [3:0]    o_op
);
    localparam int TW = NW + DW + 1;
    logic [TW-1:0] n_trial;
    logic          n_take;
    always_comb begin
        n_trial = {{(TW-NW){1'b0}}, i_rem} - ({{(TW-DW){1'b0}}, i_den} << QB);
        n_take  = !n_trial[TW-1];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_rem <= n_take ? n_trial[NW-1:0] : i_rem;
            o_quo <= i_quo | (n_take ? (NW'(1) << QB) : '0);
            o_den <= i_den;
            o_res <= i_res;
            o_flg <= i_flg;
            o_neg <= i_neg;
            o_op  <= i_op;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/fixed_point_alu_q24_8.sv
// top level of the signed fixed-point alu
// channel | dir | payload
// s_in    | in  | operation, operand_a, operand_b
// m_out   | out | result_value, compare_true, overflow, divide_by_zero
// each item passes the stage-0 registers, divide cells and output register
// one transfer per cycle while the output is not stalled
// the depth is set by the chain of divide cells, one quotient bit per cell
// the pipe advances when the output register is empty or taken
// reset clears the valid bits only
`default_nettype none
module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    fpa_if.sink      s_in,
    fpa_if.source    m_out
);
    `include "fixed_point_alu_q24_8_macros.svh"
    localparam int W  = WORD_BITS;
    localparam int NW = WORD_BITS + FRAC_BITS;
    localparam int NC = NW;

    logic en;
    assign en = !m_out.valid || m_out.ready;
    assign s_in.ready = en;

    // stage 0: all ops but multiplication and division
    logic r_vld0;
    logic [NW-1:0] r_num0;
    logic [W-1:0] r_den0, r_res0;
    logic [3:0] r_flg0, r_op0;
    logic r_neg0;
    logic [2*W-1:0] r_pa;

    logic signed [W-1:0] a, b;
    logic [W-1:0] ma, mb, n_res;
    logic [3:0] n_flg;
    logic [W:0] s_add, s_sub, s_inc, s_dec;
    logic [W+FRAC_BITS-1:0] sh_l;
    logic lt, gt;
    always_comb begin
        a = s_in.operand_a;
        b = s_in.operand_b;
        ma = a[W-1] ? W'(-a) : W'(a);
        mb = b[W-1] ? W'(-b) : W'(b);
        lt = a < b;
        gt = b < a;
        s_add = {a[W-1], a} + {b[W-1], b};
        s_sub = {a[W-1], a} - {b[W-1], b};
        s_inc = {a[W-1], a} + (W+1)'(1);
        s_dec = {a[W-1], a} - (W+1)'(1);
        sh_l = {{FRAC_BITS{a[W-1]}}, a} << FRAC_BITS;
        n_res = '0;
        n_flg = '0; // {pending mul, ovf, cmp, dz}
        case (t_op'(s_in.operation))
            OP_ADD: begin n_res = s_add[W-1:0]; n_flg[2] = s_add[W] != s_add[W-1]; end
            OP_SUB: begin n_res = s_sub[W-1:0]; n_flg[2] = s_sub[W] != s_sub[W-1]; end
            OP_MUL: n_flg[3] = 1'b1;
            OP_DIV: n_flg[0] = (b == '0);
            OP_EQ:  n_flg[1] = a == b;
            OP_NE:  n_flg[1] = a != b;
            OP_GT:  n_flg[1] = gt;
            OP_LT:  n_flg[1] = lt;
            OP_GE:  n_flg[1] = !lt;
            OP_LE:  n_flg[1] = !gt;
            OP_MIN: n_res = gt ? b : a;
            OP_MAX: n_res = gt ? a : b;
            OP_INC: begin n_res = s_inc[W-1:0]; n_flg[2] = s_inc[W] != s_inc[W-1]; end
            OP_DEC: begin n_res = s_dec[W-1:0]; n_flg[2] = s_dec[W] != s_dec[W-1]; end
            OP_TO_INT: n_res = W'(a >>> FRAC_BITS);
            default: begin
                n_res = sh_l[W-1:0];
                n_flg[2] = sh_l[W+FRAC_BITS-1:W-1] != {(FRAC_BITS+1){sh_l[W-1]}};
            end
        endcase
    end

    // stage 1: magnitude product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld0 <= 1'b0;
        else if (en) r_vld0 <= s_in.valid;
        if (en) begin
            r_num0 <= {ma, {FRAC_BITS{1'b0}}};
            r_den0 <= mb;
            r_res0 <= n_res;
            r_flg0 <= n_flg;
            r_op0  <= s_in.operation;
            r_neg0 <= a[W-1] ^ b[W-1];
            r_pa   <= (2*W)'(ma) * (2*W)'(mb);
        end
    end
    // mul post: sign, shift, fit
    logic [2*W:0] sp;
    logic [2*W:0] sh;
    logic [W-1:0] c_res;
    logic [3:0] c_flg;
    always_comb begin
        sp = r_neg0 ? -{1'b0, r_pa} : {1'b0, r_pa};
        sh = $signed(sp) >>> FRAC_BITS;
        c_res = r_res0;
        c_flg = r_flg0;
        if (r_flg0[3]) begin
            c_res = sh[W-1:0];
            c_flg[2] = sh[2*W:W-1] != {(W+2){sh[W-1]}};
        end
    end

    logic [NC:0] v;
    logic [NW-1:0] rem [NC+1];
    logic [NW-1:0] quo [NC+1];
    logic [W-1:0] den [NC+1];
    logic [W-1:0] res [NC+1];
    logic [3:0] flg [NC+1];
    logic ng [NC+1];
    logic [3:0] op [NC+1];
    assign v[0] = r_vld0;
    assign rem[0] = r_num0;
    assign quo[0] = '0;
    assign den[0] = r_den0;
    assign res[0] = c_res;
    assign flg[0] = c_flg;
    assign ng[0] = r_neg0;
    assign op[0] = r_op0;

    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            logic vq;
            fpa_cell #(.NW(NW), .DW(W), .QB(NC-1-g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(v[g]),
                .i_rem(rem[g]), .i_quo(quo[g]), .i_den(den[g]), .i_res(res[g]),
                .i_flg(flg[g]), .i_neg(ng[g]), .i_op(op[g]),
                .o_vld(vq), .o_rem(rem[g+1]), .o_quo(quo[g+1]), .o_den(den[g+1]),
                .o_res(res[g+1]), .o_flg(flg[g+1]), .o_neg(ng[g+1]), .o_op(op[g+1])
            );
            assign v[g+1] = vq;
        end
    endgenerate

    // final: divide sign and fit, output register
    logic [NW:0] sq;
    always_comb sq = ng[NC] ? -{1'b0, quo[NC]} : {1'b0, quo[NC]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_out.valid <= 1'b0;
        else if (en) m_out.valid <= v[NC];
        if (en) begin
            m_out.compare_true   <= flg[NC][1];
            m_out.divide_by_zero <= flg[NC][0];
            if (t_op'(op[NC]) == OP_DIV && !flg[NC][0]) begin
                m_out.result_value <= sq[W-1:0];
                m_out.overflow <= sq[NW:W-1] != {(FRAC_BITS+2){sq[W-1]}};
            end else begin
                m_out.result_value <= res[NC];
                m_out.overflow <= flg[NC][2];
            end
        end
    end
    assign m_out.operation = '0;
    assign m_out.operand_a = '0;
    assign m_out.operand_b = '0;

    `FPA_ASSERT_IMP(a_cmp_zero, i_clk, i_rst_n, m_out.valid && m_out.compare_true,
        m_out.result_value == '0 && !m_out.overflow)
    `FPA_ASSERT_IMP(a_dz_flags, i_clk, i_rst_n, m_out.valid && m_out.divide_by_zero,
        m_out.result_value == '0 && !m_out.overflow && !m_out.compare_true)
    `FPA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        m_out.valid && $stable(m_out.result_value))
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// testbench of the signed q24.8 fixed-point alu with a result scoreboard
`default_nettype none
module tb_top;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        logic        ovf;
        logic        dz;
    } t_alu_result;

    class t_alu_scoreboard;
        t_alu_result pending[$];
        int          errors = 0;

        function bit fits32(longint v);
            return v == {{32{v[31]}}, v[31:0]};
        endfunction

        function t_alu_result alu_predict(t_op op, logic signed [31:0] a,
                                          logic signed [31:0] b);
            t_alu_result res;
            longint      sa;
            longint      sb;
            longint      wide;
            res = '0;
            sa = a;
            sb = b;
            case (op) inside
                OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_MUL, OP_FROM_INT: begin
                    case (op)
                        OP_ADD:  wide = sa + sb;
                        OP_SUB:  wide = sa - sb;
                        OP_INC:  wide = sa + 1;
                        OP_DEC:  wide = sa - 1;
                        OP_MUL:  wide = (sa * sb) >>> 8;
                        default: wide = sa <<< 8;
                    endcase
                    res.value = wide[31:0];
                    res.ovf = !fits32(wide);
                end
                OP_DIV: begin
                    if (b == 0) begin
                        res.dz = 1'b1;
                    end else begin
                        wide = (sa <<< 8) / sb;
                        res.value = wide[31:0];
                        res.ovf = !fits32(wide);
                    end
                end
                OP_EQ: res.cmp = a == b;
                OP_NE: res.cmp = a != b;
                OP_GT: res.cmp = a > b;
                OP_LT: res.cmp = a < b;
                OP_GE: res.cmp = a >= b;
                OP_LE: res.cmp = a <= b;
                OP_MIN: res.value = (a > b) ? b : a;
                OP_MAX: res.value = (a > b) ? a : b;
                default: res.value = a >>> 8;
            endcase
            return res;
        endfunction

        function void note_input(t_op op, logic [31:0] a, logic [31:0] b);
            pending.push_back(alu_predict(op, a, b));
        endfunction

        function void check_result(t_alu_result got);
            t_alu_result exp_r;
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected: value %h", got.value);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.value !== exp_r.value) begin
                $error("result_value expected %h actual %h", exp_r.value, got.value);
                errors++;
            end
            if (got.cmp !== exp_r.cmp) begin
                $error("compare_true expected %b actual %b", exp_r.cmp, got.cmp);
                errors++;
            end
            if (got.ovf !== exp_r.ovf) begin
                $error("overflow expected %b actual %b", exp_r.ovf, got.ovf);
                errors++;
            end
            if (got.dz !== exp_r.dz) begin
                $error("divide_by_zero expected %b actual %b", exp_r.dz, got.dz);
                errors++;
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    fpa_if #(.W(32)) in_ch (i_clk);
    fpa_if #(.W(32)) out_ch (i_clk);
    t_alu_scoreboard sb;
    int  cycles;
    int  hold_left;
    bit  hold_req;
    bit  out_quiet;
    bit  in_quiet;

    fixed_point_alu_q24_8 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        in_ch.result_value = '0;
        in_ch.compare_true = 1'b0;
        in_ch.overflow = 1'b0;
        in_ch.divide_by_zero = 1'b0;
        out_ch.ready = 1'b0;
    end

    // transfer monitor and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(t_op'(in_ch.operation), in_ch.operand_a, in_ch.operand_b);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result({out_ch.result_value, out_ch.compare_true, out_ch.overflow,
                             out_ch.divide_by_zero});
    end

    initial cycles = 0;

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result receiver
    initial begin
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (out_quiet) begin
                out_ch.ready = 1'b1;
            end else begin
                hold_left = gap_len();
                out_ch.ready = (hold_left == 0);
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return '0;
            5: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(t_op op, logic [31:0] a, logic [31:0] b);
        int g;
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.operand_a = a;
        in_ch.operand_b = b;
        do @(posedge i_clk); while (!in_ch.ready);
        g = in_quiet ? 0 : gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    initial begin
        t_op op;
        int  n;
        hold_req = 1'b0;
        out_quiet = 1'b0;
        in_quiet = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
        send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_item(OP_SUB, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(OP_MUL, 32'h0000_0180, 32'hffff_fe80);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_item(OP_DIV, 32'h0000_0300, 32'h0000_0000);
        send_item(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_EQ, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_NE, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_GT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_GE, 32'h0000_0005, 32'h0000_0005);
        send_item(OP_LE, 32'h0000_0006, 32'h0000_0005);
        send_item(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_INC, 32'h7fff_ffff, 32'h0);
        send_item(OP_DEC, 32'h8000_0000, 32'h0);
        send_item(OP_DEC, 32'h0000_0100, 32'hffff_ffff);
        send_item(OP_TO_INT, 32'hffff_ff01, 32'h0);
        send_item(OP_TO_INT, 32'h8000_0000, 32'h0);
        send_item(OP_FROM_INT, 32'h0080_0000, 32'h0);
        send_item(OP_FROM_INT, 32'hff80_0000, 32'h0);

        in_quiet = 1'b0;
        for (n = 0; n < 850; n++) begin
            if (n == 150) hold_req = 1'b1;
            if (n == 400) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                while (!sb.drained()) @(posedge i_clk);
            end
            if (n == 500) begin
                in_quiet = 1'b1;
                out_quiet = 1'b1;
            end
            if (n == 600) begin
                in_quiet = 1'b0;
                out_quiet = 1'b0;
            end
            op = t_op'($urandom_range(0, 15));
            send_item(op, pick_operand(),
                      (op == OP_DIV && $urandom_range(0, 9) == 0) ? 32'h0 : pick_operand());
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (!sb.drained()) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_if.sv
hw/rtl/fpa_cell.sv
hw/rtl/fixed_point_alu_q24_8.sv
sim/tb_top.sv
